@@ design/rssi_moving_average_distance_macros.svh @@
`ifndef RSSI_MOVING_AVERAGE_DISTANCE_MACROS_SVH
`define RSSI_MOVING_AVERAGE_DISTANCE_MACROS_SVH

// expr must hold at every edge out of reset
`define AST_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// same-cycle implication
`define AST_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/rmad_pkg.sv @@
`timescale 1ns / 1ps
package rmad_pkg;

    typedef enum logic [0:0] {
        CFG_TX_POWER  = 1'b0,
        CFG_PATH_LOSS = 1'b1
    } t_cfg_idx;

    localparam logic signed [7:0] TX_RESET = -8'sd45;
    localparam logic [6:0]        PL_RESET = 7'd25;

    // log2(10), log2(1000), ln(2) in Q32
    localparam logic [33:0] C_LOG2_10   = 34'd14267572527;
    localparam logic [35:0] C_LOG2_1000 = 36'd42802717582;
    localparam logic [31:0] C_LN2       = 32'd2977044472;
    localparam logic [30:0] ONE_Q30     = 31'h40000000;
    localparam logic [4:0]  LAST_TERM   = 5'd16;

    typedef struct packed {
        logic accept;
        logic update;
        logic avg_go;
        logic avg_latch;
        logic exp_mul;
        logic exp_go;
        logic exp_latch;
        logic sat;
        logic frac;
        logic t_mul;
        logic t_rcp;
        logic t_acc;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic in_ch_ok;
        logic div_done;
        logic tot_zero;
        logic exp_lo;
        logic exp_hi;
        logic k_last;
    } t_sts;

    // floor(2^32 / k)
    function automatic logic [32:0] rcp(input logic [4:0] k);
        logic [32:0] v;
        case (k)
            5'd1:    v = 33'd4294967296;
            5'd2:    v = 33'd2147483648;
            5'd3:    v = 33'd1431655765;
            5'd4:    v = 33'd1073741824;
            5'd5:    v = 33'd858993459;
            5'd6:    v = 33'd715827882;
            5'd7:    v = 33'd613566756;
            5'd8:    v = 33'd536870912;
            5'd9:    v = 33'd477218588;
            5'd10:   v = 33'd429496729;
            5'd11:   v = 33'd390451572;
            5'd12:   v = 33'd357913941;
            5'd13:   v = 33'd330382099;
            5'd14:   v = 33'd306783378;
            5'd15:   v = 33'd286331153;
            5'd16:   v = 33'd268435456;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/rmad_div.sv @@
`timescale 1ns / 1ps
module rmad_div #(
    parameter int NW = 48,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic          o_done
);
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_nx;
    logic            ge;

    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign rem_nx = ge ? rem_sh - {1'b0, r_den} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= rem_nx[DW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

@@ design/rmad_dp.sv @@
`timescale 1ns / 1ps
module rmad_dp import rmad_pkg::*; #(
    parameter int WINDOW   = 10,
    parameter int CHANNELS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_addr,
    input  logic [7:0]        i_cfg_data,
    input  logic [1:0]        i_channel,
    input  logic signed [7:0] i_sample,
    output logic [1:0]        o_channel,
    output logic [15:0]       o_avg,
    output logic [31:0]       o_dist,
    output logic              o_dvalid
);
    localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int TW    = $clog2(128 * WINDOW) + 1;
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = CW + 10;
    localparam int PW    = NW + 34;
    localparam int DW    = CW + 7;
    localparam int YW    = PW + 2;
    localparam logic signed [YW-1:0] C1K = YW'(C_LOG2_1000);

    logic signed [7:0]    r_tx;
    logic [6:0]           r_pl;
    logic [7:0]           r_ring [DEPTH];
    logic [SW-1:0]        r_slot [CHANNELS];
    logic [CW-1:0]        r_cnt  [CHANNELS];
    logic signed [TW-1:0] r_tot  [CHANNELS];

    logic [1:0]           r_ch;
    logic [CHW-1:0]       r_ci;
    logic signed [7:0]    r_smp;
    logic [AW-1:0]        r_addr;
    logic signed [7:0]    r_old;
    logic [CW-1:0]        r_ccnt;
    logic signed [TW-1:0] r_ctot;
    logic [15:0]          r_avg;
    logic [31:0]          r_dist;
    logic                 r_dval;
    logic [PW-1:0]        r_prod;
    logic                 r_neg;
    logic [DW-1:0]        r_den;
    logic signed [YW-1:0] r_y;
    logic [29:0]          r_t;
    logic [30:0]          r_term;
    logic [30:0]          r_x;
    logic [30:0]          r_q0;
    logic [31:0]          r_sum;
    logic [4:0]           r_k;

    logic                 ch_ok;
    logic [CHW-1:0]       ci_sel;
    logic [AW-1:0]        rd_addr;
    logic                 full;
    logic [CW-1:0]        n_cnt;
    logic signed [TW-1:0] n_tot;
    logic [SW-1:0]        n_slot;
    logic [TW-1:0]        mag_tot;
    logic [PW-1:0]        avg_num;
    logic [DW-1:0]        avg_den;
    logic signed [NW-1:0] tx_x;
    logic signed [NW-1:0] cnt_x;
    logic signed [NW-1:0] tot_x;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        mag_num;
    logic [6:0]           pl_eff;
    logic [PW-1:0]        prod;
    logic [DW-1:0]        den;
    logic [PW-1:0]        quo;
    logic                 div_done;
    logic [PW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic [15:0]          avg16;
    logic signed [YW-1:0] qs;
    logic signed [YW-33:0] n_int;
    logic [63:0]          fprod;
    logic [60:0]          xprod;
    logic [63:0]          rprod;
    logic [30:0]          rem;
    logic [30:0]          q1;
    logic [5:0]           sh6;
    logic [33:0]          m34;
    logic [33:0]          half;
    logic [33:0]          rnd;
    logic [33:0]          res;
    logic [31:0]          dist_rnd;

    assign ch_ok   = int'(i_channel) < CHANNELS;
    assign ci_sel  = ch_ok ? CHW'(i_channel) : '0;
    assign rd_addr = AW'(ci_sel) * AW'(WINDOW) + AW'(r_slot[ci_sel]);

    assign full   = r_cnt[r_ci] == CW'(WINDOW);
    assign n_cnt  = full ? r_cnt[r_ci] : r_cnt[r_ci] + 1'b1;
    assign n_tot  = r_tot[r_ci] - (full ? TW'(r_old) : TW'(0)) + TW'(r_smp);
    assign n_slot = (r_slot[r_ci] == SW'(WINDOW - 1)) ? '0 : r_slot[r_ci] + 1'b1;

    assign mag_tot = r_ctot[TW-1] ? TW'(-r_ctot) : TW'(r_ctot);
    assign avg_num = (PW'(mag_tot) << 9) + PW'(r_ccnt);
    assign avg_den = DW'(r_ccnt) << 1;

    assign tx_x    = NW'(r_tx);
    assign cnt_x   = NW'(r_ccnt);
    assign tot_x   = NW'(r_ctot);
    assign num     = tx_x * cnt_x - tot_x;
    assign mag_num = num[NW-1] ? NW'(-num) : NW'(num);
    assign pl_eff  = (r_pl == 7'd0) ? 7'd1 : r_pl;
    assign prod    = PW'(mag_num) * PW'(C_LOG2_10);
    assign den     = DW'(r_ccnt) * DW'(pl_eff);

    assign div_num = i_cmd.avg_go ? avg_num : r_prod;
    assign div_den = i_cmd.avg_go ? avg_den : r_den;

    rmad_div #(.NW(PW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.avg_go | i_cmd.exp_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    assign avg16 = r_ctot[TW-1] ? 16'(-quo[15:0]) : quo[15:0];
    assign qs    = r_neg ? -$signed(YW'(quo)) : $signed(YW'(quo));
    assign n_int = r_y[YW-1:32];

    assign fprod = 64'(r_y[31:0]) * 64'(C_LN2);
    assign xprod = 61'(r_term) * 61'(r_t);
    assign rprod = 64'(r_x) * 64'(rcp(r_k));
    assign rem   = r_x - 31'(r_q0 * r_k);
    assign q1    = (rem >= 31'(r_k)) ? r_q0 + 31'd1 : r_q0;

    // n in [-1, 31]: shift right by 30 - n with rounding
    assign sh6      = 6'd30 - r_y[37:32];
    assign m34      = 34'(r_sum);
    assign half     = 34'd1 << (sh6[4:0] - 5'd1);
    assign rnd      = (m34 + half) >> sh6[4:0];
    assign res      = (r_y[37:32] == 6'd31) ? (m34 << 1) :
                      (sh6 == 6'd0) ? m34 : rnd;
    assign dist_rnd = (|res[33:32]) ? '1 : res[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= TX_RESET;
            r_pl <= PL_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                r_slot[c] <= '0;
                r_cnt[c]  <= '0;
                r_tot[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_TX_POWER:  r_tx <= i_cfg_data;
                    CFG_PATH_LOSS: r_pl <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_slot[r_ci] <= n_slot;
                r_cnt[r_ci]  <= n_cnt;
                r_tot[r_ci]  <= n_tot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old <= r_ring[rd_addr];
        end
        if (i_cmd.update) begin
            r_ring[r_addr] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch   <= i_channel;
            r_ci   <= ci_sel;
            r_smp  <= i_sample;
            r_addr <= rd_addr;
            r_avg  <= '0;
            r_dist <= '0;
            r_dval <= 1'b0;
        end
        if (i_cmd.update) begin
            r_ccnt <= n_cnt;
            r_ctot <= n_tot;
        end
        if (i_cmd.avg_latch) begin
            r_avg <= avg16;
        end
        if (i_cmd.exp_mul) begin
            r_prod <= prod;
            r_neg  <= num[NW-1];
            r_den  <= den;
        end
        if (i_cmd.exp_latch) begin
            r_y    <= qs + C1K;
            r_dval <= 1'b1;
        end
        if (i_cmd.sat) begin
            r_dist <= '1;
        end
        if (i_cmd.frac) begin
            r_t    <= fprod[63:34];
            r_term <= ONE_Q30;
            r_sum  <= 32'(ONE_Q30);
            r_k    <= 5'd1;
        end
        if (i_cmd.t_mul) begin
            r_x <= xprod[60:30];
        end
        if (i_cmd.t_rcp) begin
            r_q0 <= rprod[62:32];
        end
        if (i_cmd.t_acc) begin
            r_term <= q1;
            r_sum  <= r_sum + 32'(q1);
            r_k    <= r_k + 5'd1;
        end
        if (i_cmd.fin) begin
            r_dist <= dist_rnd;
        end
    end

    assign o_sts.in_ch_ok = ch_ok;
    assign o_sts.div_done = div_done;
    assign o_sts.tot_zero = r_ctot == '0;
    assign o_sts.exp_lo   = n_int < -1;
    assign o_sts.exp_hi   = n_int > 31;
    assign o_sts.k_last   = r_k == LAST_TERM;

    assign o_channel = r_ch;
    assign o_avg     = r_avg;
    assign o_dist    = r_dist;
    assign o_dvalid  = r_dval;
endmodule

@@ design/rmad_ctrl.sv @@
`timescale 1ns / 1ps
module rmad_ctrl import rmad_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_UPD      = 14'b00000000000010,
        S_AVG_GO   = 14'b00000000000100,
        S_AVG_WAIT = 14'b00000000001000,
        S_EXP_MUL  = 14'b00000000010000,
        S_EXP_GO   = 14'b00000000100000,
        S_EXP_WAIT = 14'b00000001000000,
        S_EXP_CHK  = 14'b00000010000000,
        S_FRAC     = 14'b00000100000000,
        S_T_MUL    = 14'b00001000000000,
        S_T_RCP    = 14'b00010000000000,
        S_T_ACC    = 14'b00100000000000,
        S_FIN      = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.in_ch_ok ? S_UPD : S_OUT;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_AVG_GO;
            end
            S_AVG_GO: begin
                o_cmd.avg_go = 1'b1;
                n_state = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.avg_latch = 1'b1;
                    n_state = i_sts.tot_zero ? S_OUT : S_EXP_MUL;
                end
            end
            S_EXP_MUL: begin
                o_cmd.exp_mul = 1'b1;
                n_state = S_EXP_GO;
            end
            S_EXP_GO: begin
                o_cmd.exp_go = 1'b1;
                n_state = S_EXP_WAIT;
            end
            S_EXP_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.exp_latch = 1'b1;
                    n_state = S_EXP_CHK;
                end
            end
            S_EXP_CHK: begin
                if (i_sts.exp_lo) begin
                    n_state = S_OUT;
                end else if (i_sts.exp_hi) begin
                    o_cmd.sat = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                o_cmd.frac = 1'b1;
                n_state = S_T_MUL;
            end
            S_T_MUL: begin
                o_cmd.t_mul = 1'b1;
                n_state = S_T_RCP;
            end
            S_T_RCP: begin
                o_cmd.t_rcp = 1'b1;
                n_state = S_T_ACC;
            end
            S_T_ACC: begin
                o_cmd.t_acc = 1'b1;
                n_state = i_sts.k_last ? S_FIN : S_T_MUL;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;
endmodule

@@ design/rssi_moving_average_distance.sv @@
`timescale 1ns / 1ps
// RSSI moving average and log-distance ranging.
// Input beat: s_axis_tuser = channel, s_axis_tdata = RSSI sample (dBm).
// Output beat: m_axis_tuser = {distance_valid, channel_out},
// m_axis_tdata = {distance_mm, average_q8}. One output beat per input beat.
// Config: i_cfg_we/i_cfg_addr/i_cfg_data write tx power (0) or path loss x10 (1);
// write only while idle.
// One sample at a time. A bit-serial divider runs twice (mean, then exponent),
// and the 2^frac series then sums 16 terms. A zero mean gives its result
// before the exponent, an exponent out of range gives it before the series,
// and a channel past CHANNELS gives it without any update.
// s_axis_tready is high only while idle; the result is held on m_axis until
// m_axis_tready, and no new sample is taken until then.
// Reset clears fill counts, totals and write slots of all channels and loads
// the config defaults; sample ring contents are not cleared.
module rssi_moving_average_distance import rmad_pkg::*; #(
    parameter int WINDOW   = 10,
    parameter int CHANNELS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rssi_sample
    input  logic [1:0]  s_axis_tuser,   // channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // average_q8, distance_mm
    output logic [2:0]  m_axis_tuser,   // channel_out, distance_valid
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);
    t_cmd        cmd;
    t_sts        sts;
    logic [1:0]  ch_out;
    logic [15:0] avg;
    logic [31:0] dist_mm;
    logic        dval;

    rmad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rmad_dp #(.WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_channel  (s_axis_tuser),
        .i_sample   (s_axis_tdata),
        .o_channel  (ch_out),
        .o_avg      (avg),
        .o_dist     (dist_mm),
        .o_dvalid   (dval)
    );

    assign m_axis_tdata = {dist_mm, avg};
    assign m_axis_tuser = {dval, ch_out};
endmodule

@@ design/rmad_checker.sv @@
`timescale 1ns / 1ps
`include "rssi_moving_average_distance_macros.svh"
module rmad_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    // one sample in flight
    `AST_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid))
    `AST_NEXT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `AST_SAME(a_invalid_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[47:16] == 32'd0)
endmodule

bind rssi_moving_average_distance rmad_sva u_rmad_sva (.*);
